// ===== hdl/fate_pkg.sv =====
package fate_pkg;

   // Payload field widths
   localparam int ACTION_W = 2;
   localparam int POS_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 3;

   // Default table depth
   localparam int DEPTH_DEFAULT = 8;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REVERSE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic [POS_W-1:0]         position;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIDX_W-1:0]   found_index;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic accept_op;     // non-search item accepted: update table, load result
      logic start_search;  // search item accepted: latch key, clear scan index
      logic scan_step;     // advance scan index
      logic finish_search; // load search result
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_search; // offered item is a search
      logic hit;       // entry under scan matches the key
      logic last;      // scan index at last entry
   } dp_sts_type;

endpackage

// ===== hdl/fate_stream_if.sv =====
interface fate_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/fate_ctrl.sv =====
module fate_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  fate_pkg::dp_sts_type  sts,
   output fate_pkg::ctl_cmd_type cmd
);
   import fate_pkg::*;

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_SCAN = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       load_rsp;

   // Take a new item only when idle and the result register is free or draining
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (sts.is_search) begin
                  cmd.start_search = 1'b1;
                  state_in         = S_SCAN;
               end else begin
                  cmd.accept_op = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (sts.hit || sts.last) begin
               cmd.finish_search = 1'b1;
               state_in          = S_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign load_rsp = cmd.accept_op || cmd.finish_search;

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/fate_dpath.sv =====
module fate_dpath #(
   parameter int DEPTH = fate_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fate_pkg::req_payload_type req_payload,
   output fate_pkg::rsp_payload_type rsp_payload,
   input  fate_pkg::ctl_cmd_type     cmd,
   output fate_pkg::dp_sts_type      sts
);
   import fate_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = $clog2(DEPTH + 1) + POS_W + 1;

   logic [VALUE_W-1:0]    store_ff [DEPTH];
   logic [VALUE_W-1:0]    store_in [DEPTH];
   logic [VALUE_W-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic [CMP_W-1:0]      pos_ext;
   logic                  pos_ok;
   logic                  is_shift_op;
   logic [IDX_W+FIDX_W-1:0] cnt_wide;

   // Position check (1-based, 1..DEPTH)
   assign pos_ext     = CMP_W'(req_payload.position);
   assign pos_ok      = (pos_ext != '0) && (pos_ext <= CMP_W'(DEPTH));
   assign is_shift_op = (req_payload.action == ACT_INSERT) ||
                        (req_payload.action == ACT_DELETE);

   // Table update: each entry keeps its word or picks its neighbor, its mirror, the new word or zero
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         store_in[k] = store_ff[k];
         if (cmd.accept_op) begin
            case (req_payload.action)
               ACT_INSERT: begin
                  if (pos_ok) begin
                     if (CMP_W'(k + 1) == pos_ext) begin
                        store_in[k] = req_payload.value;
                     end else if ((CMP_W'(k + 1) > pos_ext) && (k > 0)) begin
                        store_in[k] = store_ff[(k > 0) ? k - 1 : 0];
                     end
                  end
               end
               ACT_DELETE: begin
                  if (pos_ok) begin
                     if (k == DEPTH - 1) begin
                        store_in[k] = '0;
                     end else if (CMP_W'(k + 1) >= pos_ext) begin
                        store_in[k] = store_ff[(k < DEPTH - 1) ? k + 1 : k];
                     end
                  end
               end
               ACT_REVERSE: store_in[k] = store_ff[DEPTH - 1 - k];
               default:     store_in[k] = store_ff[k];
            endcase
         end
      end
   end

   // Search key and scan index
   always_comb begin
      key_in = key_ff;
      cnt_in = cnt_ff;
      if (cmd.start_search) begin
         key_in = req_payload.value;
         cnt_in = '0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   assign sts.is_search = (req_payload.action == ACT_SEARCH);
   assign sts.hit       = (store_ff[cnt_ff] == key_ff);
   assign sts.last      = (cnt_ff == IDX_W'(DEPTH - 1));

   // Low index bits reported on a match
   assign cnt_wide = {{FIDX_W{1'b0}}, cnt_ff};

   // Result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.accept_op) begin
         rsp_in.status      = (is_shift_op && !pos_ok) ? ST_RANGE : ST_OK;
         rsp_in.found_index = '0;
      end else if (cmd.finish_search) begin
         rsp_in.status      = sts.hit ? ST_OK : ST_ABSENT;
         rsp_in.found_index = sts.hit ? cnt_wide[FIDX_W-1:0] : '0;
      end
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            store_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < DEPTH; k++) begin
            store_ff[k] <= store_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== hdl/fixed_array_table_engine_top.sv =====
// Fixed-array table engine: DEPTH signed 32-bit words, all zero after reset.
// Each request item carries an action (insert, delete, reverse, search), a
// 1-based position and a value, and yields exactly one response item with a
// status and, on a found search, the low three bits of the first matching
// index. Insert, delete and reverse are applied on the edge the item is
// accepted, and their response is registered there. A search scans the
// table one entry per cycle through a single read port and a comparator;
// the next item is taken once the scan is done. The response sits in an
// output register; a new item is accepted while the engine is idle and
// that register is empty or being read in the same cycle.
module fixed_array_table_engine_top #(
   parameter int DEPTH = fate_pkg::DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   fate_stream_if.sink   req_ch,
   fate_stream_if.source rsp_ch
);
   import fate_pkg::*;

   ctl_cmd_type     cmd;
   dp_sts_type      sts;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   assign req_payload    = req_ch.payload;
   assign rsp_ch.payload = rsp_payload;

   fate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fate_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== tb/sv/fixed_array_table_engine_top_tb.sv =====
`timescale 1ns / 100ps

module fixed_array_table_engine_top_tb;
   import fate_pkg::*;

   localparam int DEPTH           = DEPTH_DEFAULT;
   localparam int ITEMS_PER_PHASE = 260;
   localparam int QUIET_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 20;
   localparam int REPORT_MAX      = 10;

   // Shadow copy of the element array plus the responses it still owes
   class table_shadow;
      logic [VALUE_W-1:0] words[DEPTH];
      rsp_payload_type    expected_rsp[$];
      int                 errors;

      function new();
         foreach (words[k]) words[k] = '0;
         errors = 0;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= REPORT_MAX) $display("%s", msg);
      endfunction

      // apply one accepted request and queue the response it must produce
      function void note_request(req_payload_type r);
         rsp_payload_type    rsp;
         int                 slot;
         logic [VALUE_W-1:0] held;
         rsp.status      = ST_OK;
         rsp.found_index = '0;
         slot            = int'(r.position) - 1;
         case (r.action)
            ACT_INSERT, ACT_DELETE: begin
               if (r.position < 1 || r.position > DEPTH) begin
                  rsp.status = ST_RANGE;
               end else if (r.action == ACT_INSERT) begin
                  // open a gap at the slot, last entry drops off
                  for (int k = DEPTH - 1; k > slot; k--) words[k] = words[k-1];
                  words[slot] = r.value;
               end else begin
                  // close the gap, zero-fill the tail
                  for (int k = slot; k < DEPTH - 1; k++) words[k] = words[k+1];
                  words[DEPTH-1] = '0;
               end
            end
            ACT_REVERSE: begin
               for (int k = 0; k < DEPTH / 2; k++) begin
                  held               = words[k];
                  words[k]           = words[DEPTH-1-k];
                  words[DEPTH-1-k]   = held;
               end
            end
            default: begin
               // lowest matching index wins
               rsp.status = ST_ABSENT;
               for (int k = 0; k < DEPTH; k++) begin
                  if (rsp.status == ST_ABSENT && words[k] == r.value) begin
                     rsp.status      = ST_OK;
                     rsp.found_index = FIDX_W'(k);
                  end
               end
            end
         endcase
         expected_rsp.push_back(rsp);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_rsp.size() == 0) begin
            flag($sformatf("unexpected response: status=%0d found_index=%0d",
                           got.status, got.found_index));
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status)
            flag($sformatf("status mismatch: expected %0d, got %0d", want.status, got.status));
         if (got.found_index !== want.found_index)
            flag($sformatf("found_index mismatch: expected %0d, got %0d",
                           want.found_index, got.found_index));
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   quiet_cycles;

   fate_stream_if #(.payload_type(req_payload_type)) req_if ();
   fate_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   table_shadow shadow = new();

   fixed_array_table_engine_top #(.DEPTH(DEPTH)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) shadow.note_request(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) shadow.check_response(rsp_if.payload);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // drive one request item, with random idle cycles ahead of it
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [POS_W-1:0]    pos,
                               input logic [VALUE_W-1:0]  val);
      req_payload_type item;
      item.action   = act;
      item.position = pos;
      item.value    = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // hold off requests until every owed response is back
   task automatic drain_table();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // small numbers and corner words collide often, so searches hit
   function automatic logic [VALUE_W-1:0] pick_word();
      logic [VALUE_W-1:0] w;
      case ($urandom_range(3))
         0: w = VALUE_W'($urandom_range(15));
         1: begin
            case ($urandom_range(3))
               0:       w = '0;
               1:       w = '1;
               2:       w = 32'h7fff_ffff;
               default: w = 32'h8000_0000;
            endcase
         end
         default: w = $urandom();
      endcase
      return w;
   endfunction

   task automatic send_random();
      logic [ACTION_W-1:0] act;
      logic [POS_W-1:0]    pos;
      logic [VALUE_W-1:0]  val;
      int                  roll;
      roll = $urandom_range(99);
      if (roll < 40)      act = ACT_INSERT;
      else if (roll < 60) act = ACT_DELETE;
      else if (roll < 70) act = ACT_REVERSE;
      else                act = ACT_SEARCH;
      pos = POS_W'($urandom_range(15));
      if ((act == ACT_INSERT || act == ACT_DELETE) && $urandom_range(99) < 85)
         pos = POS_W'($urandom_range(DEPTH, 1));
      // searches mostly look for a word that is currently stored
      if (act == ACT_SEARCH && $urandom_range(99) < 60)
         val = shadow.words[$urandom_range(DEPTH - 1)];
      else
         val = pick_word();
      send_request(act, pos, val);
   endtask

   task automatic run_directed();
      send_request(ACT_SEARCH,  4'd0,  32'h0000_0000);   // hit on cleared array
      send_request(ACT_SEARCH,  4'd0,  32'h0000_0001);   // miss
      send_request(ACT_INSERT,  4'd0,  32'h1111_1111);   // bad positions
      send_request(ACT_INSERT,  4'd9,  32'h2222_2222);
      send_request(ACT_INSERT,  4'd15, 32'hffff_ffff);
      send_request(ACT_DELETE,  4'd0,  32'h0000_0000);
      send_request(ACT_DELETE,  4'd15, 32'hffff_ffff);
      send_request(ACT_INSERT,  4'd1,  32'h7fff_ffff);
      send_request(ACT_INSERT,  4'd8,  32'h8000_0000);   // last slot replaced
      send_request(ACT_INSERT,  4'd1,  32'hffff_ffff);
      send_request(ACT_INSERT,  4'd4,  32'h5a5a_5a5a);
      send_request(ACT_INSERT,  4'd2,  32'ha5a5_a5a5);
      send_request(ACT_SEARCH,  4'd15, 32'h8000_0000);
      send_request(ACT_SEARCH,  4'd0,  32'h7fff_ffff);
      send_request(ACT_REVERSE, 4'd15, 32'hffff_ffff);   // position and value unused
      send_request(ACT_SEARCH,  4'd3,  32'h8000_0000);
      send_request(ACT_DELETE,  4'd8,  32'h1234_5678);   // last slot cleared only
      send_request(ACT_DELETE,  4'd1,  32'hffff_ffff);
      send_request(ACT_SEARCH,  4'd0,  32'h0000_0000);
      send_request(ACT_REVERSE, 4'd0,  32'h0000_0000);
      send_request(ACT_SEARCH,  4'd7,  32'h5a5a_5a5a);
      send_request(ACT_SEARCH,  4'd0,  32'h1234_5678);
      send_request(ACT_INSERT,  4'd8,  32'h0000_0001);
      send_request(ACT_SEARCH,  4'd15, 32'h0000_0001);
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain_table();

      // idle mix per phase: none, sender, receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         repeat (ITEMS_PER_PHASE) send_random();
         drain_table();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.outstanding() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
